// ----- rtl/clex_pkg.sv -----
package clex_pkg;

  // default field widths
  localparam int OFFSET_BITS_DEF = 32;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int LINE_BITS_DEF   = 24;
  localparam int KIND_BITS       = 6;

  // most results one input item can cause
  localparam int MAX_RESULTS = 3;

  // lexer mode between bytes
  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_IDENT   = 4'd1,
    M_INT     = 4'd2,
    M_FLOAT   = 4'd3,
    M_STRING  = 4'd4,
    M_COMMENT = 4'd5,
    M_SLASH   = 4'd6,
    M_EQ      = 4'd7,
    M_BANG    = 4'd8,
    M_LT      = 4'd9,
    M_GT      = 4'd10,
    M_AMP     = 4'd11,
    M_PIPE    = 4'd12
  } lex_mode_t;

  // token kinds
  localparam logic [KIND_BITS-1:0] K_IDENT    = 6'd0;
  localparam logic [KIND_BITS-1:0] K_INT      = 6'd1;
  localparam logic [KIND_BITS-1:0] K_FLOAT    = 6'd2;
  localparam logic [KIND_BITS-1:0] K_STRING   = 6'd3;
  localparam logic [KIND_BITS-1:0] K_COLON    = 6'd4;
  localparam logic [KIND_BITS-1:0] K_ASSIGN   = 6'd5;
  localparam logic [KIND_BITS-1:0] K_LBRACE   = 6'd6;
  localparam logic [KIND_BITS-1:0] K_RBRACE   = 6'd7;
  localparam logic [KIND_BITS-1:0] K_LBRACK   = 6'd8;
  localparam logic [KIND_BITS-1:0] K_RBRACK   = 6'd9;
  localparam logic [KIND_BITS-1:0] K_LPAREN   = 6'd10;
  localparam logic [KIND_BITS-1:0] K_RPAREN   = 6'd11;
  localparam logic [KIND_BITS-1:0] K_STAR     = 6'd12;
  localparam logic [KIND_BITS-1:0] K_MINUS    = 6'd13;
  localparam logic [KIND_BITS-1:0] K_SLASH    = 6'd14;
  localparam logic [KIND_BITS-1:0] K_PLUS     = 6'd15;
  localparam logic [KIND_BITS-1:0] K_TILDE    = 6'd16;
  localparam logic [KIND_BITS-1:0] K_BANG     = 6'd17;
  localparam logic [KIND_BITS-1:0] K_LT       = 6'd18;
  localparam logic [KIND_BITS-1:0] K_GT       = 6'd19;
  localparam logic [KIND_BITS-1:0] K_LE       = 6'd20;
  localparam logic [KIND_BITS-1:0] K_GE       = 6'd21;
  localparam logic [KIND_BITS-1:0] K_EQ       = 6'd22;
  localparam logic [KIND_BITS-1:0] K_NE       = 6'd23;
  localparam logic [KIND_BITS-1:0] K_SHL      = 6'd24;
  localparam logic [KIND_BITS-1:0] K_SHR      = 6'd25;
  localparam logic [KIND_BITS-1:0] K_AMP      = 6'd26;
  localparam logic [KIND_BITS-1:0] K_PIPE     = 6'd27;
  localparam logic [KIND_BITS-1:0] K_CARET    = 6'd28;
  localparam logic [KIND_BITS-1:0] K_AND      = 6'd29;
  localparam logic [KIND_BITS-1:0] K_OR       = 6'd30;
  localparam logic [KIND_BITS-1:0] K_AT       = 6'd31;
  localparam logic [KIND_BITS-1:0] K_SEMI     = 6'd32;
  localparam logic [KIND_BITS-1:0] K_END      = 6'd33;
  localparam logic [KIND_BITS-1:0] K_BAD      = 6'd34;
  localparam logic [KIND_BITS-1:0] K_DOT      = 6'd35;
  localparam logic [KIND_BITS-1:0] K_OPEN_STR = 6'd36;

  // characters with a role of their own
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

endpackage

// ----- rtl/clex_step.sv -----
module clex_step #(
  parameter int OB = clex_pkg::OFFSET_BITS_DEF,
  parameter int LB = clex_pkg::LENGTH_BITS_DEF,
  parameter int NB = clex_pkg::LINE_BITS_DEF,
  localparam int RW = clex_pkg::KIND_BITS + OB + LB + NB
) (
  input  logic [7:0]                  text_byte,
  input  logic                        byte_present,
  input  logic                        end_of_text,
  input  clex_pkg::lex_mode_t         lex_mode,
  input  logic [OB-1:0]               pending_start,
  input  logic [LB-1:0]               pending_length,
  input  logic [NB-1:0]               pending_line,
  input  logic [NB-1:0]               line_count,
  input  logic [OB-1:0]               byte_offset,
  input  logic                        halted_on_error,
  output clex_pkg::lex_mode_t         lex_mode_next,
  output logic [OB-1:0]               pending_start_next,
  output logic [LB-1:0]               pending_length_next,
  output logic [NB-1:0]               pending_line_next,
  output logic [NB-1:0]               line_count_next,
  output logic [OB-1:0]               byte_offset_next,
  output logic                        halted_on_error_next,
  output logic [1:0]                  res_count,
  output logic [2:0][RW-1:0]          res_data
);

  typedef struct packed {
    logic                          hit;
    logic [clex_pkg::KIND_BITS-1:0] kind;
  } op_t;

  // candidate results in emission order: continue, start, pending at end, end token
  logic [3:0]          cv;
  logic [3:0][RW-1:0]  cd;
  logic                consumed;
  logic [OB-1:0]       p;
  op_t                 op;
  logic [1:0]          rc;

  function automatic logic [RW-1:0] pack(input logic [clex_pkg::KIND_BITS-1:0] k,
                                         input logic [OB-1:0] s,
                                         input logic [LB-1:0] l,
                                         input logic [NB-1:0] n);
    return {n, l, s, k};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    // space, tab, lf, cr, ff, nul
    return (c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C, 8'h00});
  endfunction

  function automatic logic [LB-1:0] sat_len(input logic [LB-1:0] l);
    return (l == '1) ? l : l + LB'(1);
  endfunction

  function automatic logic [NB-1:0] sat_line(input logic [NB-1:0] n);
    return (n == '1) ? n : n + NB'(1);
  endfunction

  // operators that are complete on their own
  function automatic op_t single_kind(input logic [7:0] c);
    op_t r;
    r.hit = 1'b1;
    case (c)
      8'h3A:   r.kind = clex_pkg::K_COLON;   // :
      8'h7B:   r.kind = clex_pkg::K_LBRACE;  // {
      8'h7D:   r.kind = clex_pkg::K_RBRACE;  // }
      8'h5B:   r.kind = clex_pkg::K_LBRACK;  // [
      8'h5D:   r.kind = clex_pkg::K_RBRACK;  // ]
      8'h28:   r.kind = clex_pkg::K_LPAREN;  // (
      8'h29:   r.kind = clex_pkg::K_RPAREN;  // )
      8'h2A:   r.kind = clex_pkg::K_STAR;    // *
      8'h2D:   r.kind = clex_pkg::K_MINUS;   // -
      8'h2B:   r.kind = clex_pkg::K_PLUS;    // +
      8'h7E:   r.kind = clex_pkg::K_TILDE;   // ~
      8'h5E:   r.kind = clex_pkg::K_CARET;   // ^
      8'h40:   r.kind = clex_pkg::K_AT;      // @
      8'h3B:   r.kind = clex_pkg::K_SEMI;    // ;
      default: begin
        r.hit  = 1'b0;
        r.kind = clex_pkg::K_BAD;
      end
    endcase
    return r;
  endfunction

  // pending operator standing alone
  function automatic op_t op_alone(input clex_pkg::lex_mode_t m);
    op_t r;
    r.hit = 1'b1;
    case (m)
      clex_pkg::M_EQ:   r.kind = clex_pkg::K_ASSIGN;
      clex_pkg::M_BANG: r.kind = clex_pkg::K_BANG;
      clex_pkg::M_LT:   r.kind = clex_pkg::K_LT;
      clex_pkg::M_GT:   r.kind = clex_pkg::K_GT;
      clex_pkg::M_AMP:  r.kind = clex_pkg::K_AMP;
      clex_pkg::M_PIPE: r.kind = clex_pkg::K_PIPE;
      default: begin
        r.hit  = 1'b0;
        r.kind = clex_pkg::K_BAD;
      end
    endcase
    return r;
  endfunction

  // pending operator joined by a second character
  function automatic op_t op_pair(input clex_pkg::lex_mode_t m, input logic [7:0] c);
    op_t r;
    r.hit  = 1'b0;
    r.kind = clex_pkg::K_BAD;
    case (m)
      clex_pkg::M_EQ: begin
        if (c == clex_pkg::CH_EQ) r = '{1'b1, clex_pkg::K_EQ};
      end
      clex_pkg::M_BANG: begin
        if (c == clex_pkg::CH_EQ) r = '{1'b1, clex_pkg::K_NE};
      end
      clex_pkg::M_LT: begin
        if (c == clex_pkg::CH_EQ) r = '{1'b1, clex_pkg::K_LE};
        else if (c == clex_pkg::CH_LT) r = '{1'b1, clex_pkg::K_SHL};
      end
      clex_pkg::M_GT: begin
        if (c == clex_pkg::CH_EQ) r = '{1'b1, clex_pkg::K_GE};
        else if (c == clex_pkg::CH_GT) r = '{1'b1, clex_pkg::K_SHR};
      end
      clex_pkg::M_AMP: begin
        if (c == clex_pkg::CH_AMP) r = '{1'b1, clex_pkg::K_AND};
      end
      clex_pkg::M_PIPE: begin
        if (c == clex_pkg::CH_PIPE) r = '{1'b1, clex_pkg::K_OR};
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // one byte of lexing, then the end of stream handling
  always_comb begin
    lex_mode_next        = lex_mode;
    pending_start_next   = pending_start;
    pending_length_next  = pending_length;
    pending_line_next    = pending_line;
    line_count_next      = line_count;
    byte_offset_next     = byte_offset;
    halted_on_error_next = halted_on_error;
    cv       = '0;
    cd       = '0;
    consumed = 1'b0;
    p        = byte_offset;
    op       = '0;

    if (byte_present && !halted_on_error) begin
      // carry on with the token in progress
      case (lex_mode)
        clex_pkg::M_IDLE: consumed = 1'b0;
        clex_pkg::M_IDENT: begin
          if (is_letter(text_byte) || is_digit(text_byte) || text_byte == clex_pkg::CH_UNDER)
          begin
            pending_length_next = sat_len(pending_length);
            consumed = 1'b1;
          end else begin
            cv[0] = 1'b1;
            cd[0] = pack(clex_pkg::K_IDENT, pending_start, pending_length, pending_line);
            lex_mode_next = clex_pkg::M_IDLE;
          end
        end
        clex_pkg::M_INT, clex_pkg::M_FLOAT: begin
          if (is_digit(text_byte)) begin
            pending_length_next = sat_len(pending_length);
            consumed = 1'b1;
          end else if (text_byte == clex_pkg::CH_DOT) begin
            consumed = 1'b1;
            if (lex_mode == clex_pkg::M_INT) begin
              lex_mode_next = clex_pkg::M_FLOAT;
              pending_length_next = sat_len(pending_length);
            end else begin
              cv[0] = 1'b1;
              cd[0] = pack(clex_pkg::K_DOT, p, LB'(1), line_count);
              halted_on_error_next = 1'b1;
              lex_mode_next = clex_pkg::M_IDLE;
            end
          end else begin
            cv[0] = 1'b1;
            cd[0] = pack((lex_mode == clex_pkg::M_INT) ? clex_pkg::K_INT : clex_pkg::K_FLOAT,
                         pending_start, pending_length, pending_line);
            lex_mode_next = clex_pkg::M_IDLE;
          end
        end
        clex_pkg::M_STRING: begin
          consumed = 1'b1;
          if (text_byte == clex_pkg::CH_QUOTE) begin
            cv[0] = 1'b1;
            cd[0] = pack(clex_pkg::K_STRING, pending_start, pending_length, pending_line);
            lex_mode_next = clex_pkg::M_IDLE;
          end else begin
            if (text_byte == clex_pkg::CH_LF) line_count_next = sat_line(line_count);
            pending_length_next = sat_len(pending_length);
          end
        end
        clex_pkg::M_COMMENT: begin
          consumed = 1'b1;
          if (text_byte == clex_pkg::CH_LF) begin
            line_count_next = sat_line(line_count);
            lex_mode_next = clex_pkg::M_IDLE;
          end
        end
        clex_pkg::M_SLASH: begin
          if (text_byte == clex_pkg::CH_SLASH) begin
            lex_mode_next = clex_pkg::M_COMMENT;
            consumed = 1'b1;
          end else begin
            cv[0] = 1'b1;
            cd[0] = pack(clex_pkg::K_SLASH, pending_start, LB'(1), pending_line);
            lex_mode_next = clex_pkg::M_IDLE;
          end
        end
        default: begin
          op = op_pair(lex_mode, text_byte);
          if (op.hit && text_byte != clex_pkg::CH_NUL) begin
            cv[0] = 1'b1;
            cd[0] = pack(op.kind, pending_start, LB'(2), pending_line);
            consumed = 1'b1;
          end else begin
            op = op_alone(lex_mode);
            cv[0] = op.hit;
            cd[0] = pack(op.kind, pending_start, LB'(1), pending_line);
          end
          lex_mode_next = clex_pkg::M_IDLE;
        end
      endcase

      // byte not taken by the previous token opens a new one
      if (!consumed && !halted_on_error_next) begin
        if (is_blank(text_byte)) begin
          if (text_byte == clex_pkg::CH_LF) line_count_next = sat_line(line_count_next);
        end else begin
          pending_start_next  = p;
          pending_line_next   = line_count_next;
          pending_length_next = LB'(1);
          if (is_letter(text_byte) || text_byte == clex_pkg::CH_UNDER) begin
            lex_mode_next = clex_pkg::M_IDENT;
          end else if (is_digit(text_byte)) begin
            lex_mode_next = clex_pkg::M_INT;
          end else begin
            case (text_byte)
              clex_pkg::CH_QUOTE: begin
                pending_start_next  = p + OB'(1);
                pending_length_next = '0;
                lex_mode_next = clex_pkg::M_STRING;
              end
              clex_pkg::CH_SLASH: lex_mode_next = clex_pkg::M_SLASH;
              clex_pkg::CH_EQ:    lex_mode_next = clex_pkg::M_EQ;
              clex_pkg::CH_BANG:  lex_mode_next = clex_pkg::M_BANG;
              clex_pkg::CH_LT:    lex_mode_next = clex_pkg::M_LT;
              clex_pkg::CH_GT:    lex_mode_next = clex_pkg::M_GT;
              clex_pkg::CH_AMP:   lex_mode_next = clex_pkg::M_AMP;
              clex_pkg::CH_PIPE:  lex_mode_next = clex_pkg::M_PIPE;
              default: begin
                op = single_kind(text_byte);
                cv[1] = 1'b1;
                if (op.hit) begin
                  cd[1] = pack(op.kind, p, LB'(1), line_count_next);
                end else begin
                  cd[1] = pack(clex_pkg::K_BAD, p, LB'(1), line_count_next);
                  halted_on_error_next = 1'b1;
                  lex_mode_next = clex_pkg::M_IDLE;
                end
              end
            endcase
          end
        end
      end
      byte_offset_next = p + OB'(1);
    end

    // end of stream: flush, end token (none after an open string or an error), back to reset values
    if (end_of_text) begin
      if (!halted_on_error_next) begin
        cv[3] = 1'b1;
        cd[3] = pack(clex_pkg::K_END, byte_offset_next, '0, line_count_next);
        case (lex_mode_next)
          clex_pkg::M_IDLE, clex_pkg::M_COMMENT: cv[2] = 1'b0;
          clex_pkg::M_IDENT: begin
            cv[2] = 1'b1;
            cd[2] = pack(clex_pkg::K_IDENT, pending_start_next, pending_length_next,
                         pending_line_next);
          end
          clex_pkg::M_INT: begin
            cv[2] = 1'b1;
            cd[2] = pack(clex_pkg::K_INT, pending_start_next, pending_length_next,
                         pending_line_next);
          end
          clex_pkg::M_FLOAT: begin
            cv[2] = 1'b1;
            cd[2] = pack(clex_pkg::K_FLOAT, pending_start_next, pending_length_next,
                         pending_line_next);
          end
          clex_pkg::M_STRING: begin
            cv[2] = 1'b1;
            cd[2] = pack(clex_pkg::K_OPEN_STR, pending_start_next, pending_length_next,
                         pending_line_next);
            cv[3] = 1'b0;
          end
          clex_pkg::M_SLASH: begin
            cv[2] = 1'b1;
            cd[2] = pack(clex_pkg::K_SLASH, pending_start_next, LB'(1), pending_line_next);
          end
          default: begin
            op = op_alone(lex_mode_next);
            cv[2] = op.hit;
            cd[2] = pack(op.kind, pending_start_next, LB'(1), pending_line_next);
          end
        endcase
      end
      lex_mode_next        = clex_pkg::M_IDLE;
      pending_start_next   = '0;
      pending_length_next  = '0;
      pending_line_next    = NB'(1);
      line_count_next      = NB'(1);
      byte_offset_next     = '0;
      halted_on_error_next = 1'b0;
    end
  end

  // pack the candidates into consecutive result slots
  always_comb begin
    rc       = '0;
    res_data = '0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i] && rc != 2'd3) begin
        res_data[rc] = cd[i];
        rc = rc + 2'd1;
      end
    end
  end

  assign res_count = rc;

endmodule

// ----- rtl/clex_rbuf.sv -----
module clex_rbuf #(
  parameter int OB = clex_pkg::OFFSET_BITS_DEF,
  parameter int LB = clex_pkg::LENGTH_BITS_DEF,
  parameter int NB = clex_pkg::LINE_BITS_DEF,
  localparam int RW = clex_pkg::KIND_BITS + OB + LB + NB,
  localparam int TW = ((RW + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [1:0]          load_count,
  input  logic [2:0][RW-1:0]  load_data,
  output logic                load_ok,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [TW-1:0]       m_tdata,
  output logic                m_tlast
);

  logic [2:0][RW-1:0] slots;
  logic [1:0]         cnt;
  logic               take;

  assign take     = m_tvalid && m_tready;
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = TW'(slots[0]);
  assign m_tlast  = (cnt == 2'd1);
  // a new item's results may enter once the current ones are gone or the last of them is leaving
  assign load_ok  = (cnt == 2'd0) || (cnt == 2'd1 && m_tready);

  // results left of the current item
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= load_count;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  // result slots, shifted down as each result is taken
  always_ff @(posedge clk) begin
    if (load) begin
      slots <= load_data;
    end else if (take) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

endmodule

// ----- rtl/c_style_token_lexer.sv -----
// An accepted byte is held in the input register and its tokens in the result buffer.
// Throughput: one byte per cycle while each byte causes at most one token and the output
// is not stalled; else later bytes wait till the last token leaves the single result port.
// The input register takes the next byte while earlier tokens still wait.
// Reset (synchronous, active high) empties both stages and returns the lexer to idle,
// line 1, offset 0.
module c_style_token_lexer #(
  parameter int OFFSET_BITS = clex_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = clex_pkg::LENGTH_BITS_DEF,
  parameter int LINE_BITS   = clex_pkg::LINE_BITS_DEF,
  localparam int RW = clex_pkg::KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS,
  localparam int TW = ((RW + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // text_byte
  input  logic          s_tuser,   // byte_present
  input  logic          s_tlast,   // end_of_text
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [TW-1:0] m_tdata,   // token_kind, token_start, token_length, token_line, pad
  output logic          m_tlast    // final_token
);

  logic                a_valid;
  logic [7:0]          a_byte;
  logic                a_present;
  logic                a_last;
  logic                a_fire;
  logic                load_ok;

  clex_pkg::lex_mode_t    lex_mode, lex_mode_next;
  logic [OFFSET_BITS-1:0] pending_start, pending_start_next;
  logic [LENGTH_BITS-1:0] pending_length, pending_length_next;
  logic [LINE_BITS-1:0]   pending_line, pending_line_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic                   halted_on_error, halted_on_error_next;
  logic [1:0]             res_count;
  logic [2:0][RW-1:0]     res_data;

  // item leaves the input register when its results fit
  assign a_fire   = a_valid && (res_count == 2'd0 || load_ok);
  assign s_tready = !a_valid || a_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_byte    <= s_tdata;
      a_present <= s_tuser;
      a_last    <= s_tlast;
    end
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode        <= clex_pkg::M_IDLE;
      pending_start   <= '0;
      pending_length  <= '0;
      pending_line    <= LINE_BITS'(1);
      line_count      <= LINE_BITS'(1);
      byte_offset     <= '0;
      halted_on_error <= 1'b0;
    end else if (a_fire) begin
      lex_mode        <= lex_mode_next;
      pending_start   <= pending_start_next;
      pending_length  <= pending_length_next;
      pending_line    <= pending_line_next;
      line_count      <= line_count_next;
      byte_offset     <= byte_offset_next;
      halted_on_error <= halted_on_error_next;
    end
  end

  clex_step #(
    .OB(OFFSET_BITS),
    .LB(LENGTH_BITS),
    .NB(LINE_BITS)
  ) u_step (
    .text_byte            (a_byte),
    .byte_present         (a_present),
    .end_of_text          (a_last),
    .lex_mode             (lex_mode),
    .pending_start        (pending_start),
    .pending_length       (pending_length),
    .pending_line         (pending_line),
    .line_count           (line_count),
    .byte_offset          (byte_offset),
    .halted_on_error      (halted_on_error),
    .lex_mode_next        (lex_mode_next),
    .pending_start_next   (pending_start_next),
    .pending_length_next  (pending_length_next),
    .pending_line_next    (pending_line_next),
    .line_count_next      (line_count_next),
    .byte_offset_next     (byte_offset_next),
    .halted_on_error_next (halted_on_error_next),
    .res_count            (res_count),
    .res_data             (res_data)
  );

  clex_rbuf #(
    .OB(OFFSET_BITS),
    .LB(LENGTH_BITS),
    .NB(LINE_BITS)
  ) u_rbuf (
    .clk        (clk),
    .rst        (rst),
    .load       (a_fire && res_count != 2'd0),
    .load_count (res_count),
    .load_data  (res_data),
    .load_ok    (load_ok),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

  localparam int OFF_W    = clex_pkg::OFFSET_BITS_DEF;
  localparam int LEN_W    = clex_pkg::LENGTH_BITS_DEF;
  localparam int LINE_W   = clex_pkg::LINE_BITS_DEF;
  localparam int KIND_W   = clex_pkg::KIND_BITS;
  localparam int TOKEN_W  = ((KIND_W + OFF_W + LEN_W + LINE_W + 7) / 8) * 8;
  localparam int START_LO = KIND_W;
  localparam int LEN_LO   = START_LO + OFF_W;
  localparam int LINE_LO  = LEN_LO + LEN_W;

  // character pools for random source text
  localparam string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam string OP_ONE     = ":={}[]()*-/+~!<>&|^@;";
  localparam string OP_TWO     = "<=>===!=<<>>&&||";
  localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, clex_pkg::CH_LF, 8'h0D, 8'h0C,
                                        clex_pkg::CH_NUL};

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  start;
    logic [LEN_W-1:0]  length;
    logic [LINE_W-1:0] line;
    logic              last;
  } token_t;

  // one directed request, with its single token written out where obvious
  typedef struct packed {
    logic [7:0]        ch;
    logic              pres;
    logic              eot;
    logic              typed;
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  start;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] line;
  } row_t;

  localparam row_t SCRIPT [25] = '{
    '{ch: "@", pres: 1'b1, eot: 1'b0, typed: 1'b1, kind: clex_pkg::K_AT,
      start: 32'd0, len: 16'd1, line: 24'd1},
    '{ch: clex_pkg::CH_NUL, pres: 1'b1, default: '0},
    '{ch: clex_pkg::CH_LF, pres: 1'b1, default: '0},
    '{ch: "a", pres: 1'b1, default: '0},
    '{ch: clex_pkg::CH_UNDER, pres: 1'b1, default: '0},
    '{ch: "9", pres: 1'b1, default: '0},
    '{ch: clex_pkg::CH_LT, pres: 1'b1, eot: 1'b0, typed: 1'b1, kind: clex_pkg::K_IDENT,
      start: 32'd3, len: 16'd3, line: 24'd2},
    '{ch: clex_pkg::CH_LT, pres: 1'b1, eot: 1'b0, typed: 1'b1, kind: clex_pkg::K_SHL,
      start: 32'd6, len: 16'd2, line: 24'd2},
    '{ch: 8'hA5, pres: 1'b0, default: '0},
    '{ch: "1", pres: 1'b1, default: '0},
    '{ch: clex_pkg::CH_DOT, pres: 1'b1, default: '0},
    '{ch: clex_pkg::CH_SLASH, pres: 1'b1, eot: 1'b0, typed: 1'b1, kind: clex_pkg::K_FLOAT,
      start: 32'd8, len: 16'd2, line: 24'd2},
    '{ch: clex_pkg::CH_SLASH, pres: 1'b1, default: '0},
    '{ch: 8'hFF, pres: 1'b1, default: '0},
    '{ch: clex_pkg::CH_LF, pres: 1'b1, default: '0},
    '{ch: clex_pkg::CH_QUOTE, pres: 1'b1, default: '0},
    '{ch: clex_pkg::CH_QUOTE, pres: 1'b1, eot: 1'b0, typed: 1'b1, kind: clex_pkg::K_STRING,
      start: 32'd15, len: 16'd0, line: 24'd3},
    '{ch: "7", pres: 1'b1, default: '0},
    '{ch: clex_pkg::CH_DOT, pres: 1'b1, default: '0},
    '{ch: clex_pkg::CH_DOT, pres: 1'b1, eot: 1'b0, typed: 1'b1, kind: clex_pkg::K_DOT,
      start: 32'd18, len: 16'd1, line: 24'd3},
    '{ch: "q", pres: 1'b1, default: '0},
    '{ch: 8'h5A, pres: 1'b0, eot: 1'b1, default: '0},
    '{ch: clex_pkg::CH_QUOTE, pres: 1'b1, eot: 1'b1, typed: 1'b1,
      kind: clex_pkg::K_OPEN_STR, start: 32'd1, len: 16'd0, line: 24'd1},
    '{ch: clex_pkg::CH_GT, pres: 1'b1, eot: 1'b1, default: '0},
    '{ch: 8'h80, pres: 1'b1, eot: 1'b1, typed: 1'b1, kind: clex_pkg::K_BAD,
      start: 32'd0, len: 16'd1, line: 24'd1}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;   // text_byte
  logic               s_tuser = 1'b0; // byte_present
  logic               s_tlast = 1'b0; // end_of_text
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TOKEN_W-1:0] m_tdata;        // token_kind, token_start, token_length, token_line, pad
  logic               m_tlast;        // final_token

  c_style_token_lexer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // lexer state mirrored on the bench side
  clex_pkg::lex_mode_t lx_mode = clex_pkg::M_IDLE;
  logic [OFF_W-1:0]    tok_start = '0;
  logic [LEN_W-1:0]    tok_len = '0;
  logic [LINE_W-1:0]   tok_line = LINE_W'(1);
  logic [LINE_W-1:0]   cur_line = LINE_W'(1);
  logic [OFF_W-1:0]    cur_off = '0;
  bit                  stopped = 1'b0;

  token_t     token_q[$];
  token_t     step_toks[$];
  logic [7:0] text[$];
  bit         quiet_tx = 1'b0;
  bit         quiet_rx = 1'b0;
  int         err_count = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < 100)
      $display("token %s wrong at t=%0t: got %0d, want %0d", what, $time, got, want);
    err_count++;
  endtask

  // character classes
  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_gap(logic [7:0] c);
    return c inside {8'h20, 8'h09, clex_pkg::CH_LF, 8'h0D, 8'h0C, clex_pkg::CH_NUL};
  endfunction

  function automatic void clear_lexer();
    lx_mode   = clex_pkg::M_IDLE;
    tok_start = '0;
    tok_len   = '0;
    tok_line  = LINE_W'(1);
    cur_line  = LINE_W'(1);
    cur_off   = '0;
    stopped   = 1'b0;
  endfunction

  function automatic void put_token(int k, logic [OFF_W-1:0] s, logic [LEN_W-1:0] n,
                                    logic [LINE_W-1:0] l);
    token_t t;
    t.kind   = KIND_W'(k);
    t.start  = s;
    t.length = n;
    t.line   = l;
    t.last   = 1'b0;
    step_toks.push_back(t);
  endfunction

  // line count and lengths saturate
  function automatic void next_line();
    if (cur_line != '1) cur_line = cur_line + LINE_W'(1);
  endfunction

  function automatic void grow();
    if (tok_len != '1) tok_len = tok_len + LEN_W'(1);
  endfunction

  function automatic void fail_at(int k, logic [OFF_W-1:0] p);
    put_token(k, p, LEN_W'(1), cur_line);
    stopped = 1'b1;
    lx_mode = clex_pkg::M_IDLE;
  endfunction

  function automatic int single_op(logic [7:0] c);
    case (c)
      ":": return clex_pkg::K_COLON;
      "{": return clex_pkg::K_LBRACE;
      "}": return clex_pkg::K_RBRACE;
      "[": return clex_pkg::K_LBRACK;
      "]": return clex_pkg::K_RBRACK;
      "(": return clex_pkg::K_LPAREN;
      ")": return clex_pkg::K_RPAREN;
      "*": return clex_pkg::K_STAR;
      "-": return clex_pkg::K_MINUS;
      "+": return clex_pkg::K_PLUS;
      "~": return clex_pkg::K_TILDE;
      "^": return clex_pkg::K_CARET;
      "@": return clex_pkg::K_AT;
      ";": return clex_pkg::K_SEMI;
      default: return -1;
    endcase
  endfunction

  // two-character operator formed by a pending first character and c
  function automatic int pair_op(clex_pkg::lex_mode_t m, logic [7:0] c);
    case (m)
      clex_pkg::M_EQ:   if (c == clex_pkg::CH_EQ) return clex_pkg::K_EQ;
      clex_pkg::M_BANG: if (c == clex_pkg::CH_EQ) return clex_pkg::K_NE;
      clex_pkg::M_LT: begin
        if (c == clex_pkg::CH_EQ) return clex_pkg::K_LE;
        if (c == clex_pkg::CH_LT) return clex_pkg::K_SHL;
      end
      clex_pkg::M_GT: begin
        if (c == clex_pkg::CH_EQ) return clex_pkg::K_GE;
        if (c == clex_pkg::CH_GT) return clex_pkg::K_SHR;
      end
      clex_pkg::M_AMP:  if (c == clex_pkg::CH_AMP) return clex_pkg::K_AND;
      clex_pkg::M_PIPE: if (c == clex_pkg::CH_PIPE) return clex_pkg::K_OR;
      default: ;
    endcase
    return -1;
  endfunction

  // pending operator standing on its own
  function automatic int lone_op(clex_pkg::lex_mode_t m);
    case (m)
      clex_pkg::M_SLASH: return clex_pkg::K_SLASH;
      clex_pkg::M_EQ:    return clex_pkg::K_ASSIGN;
      clex_pkg::M_BANG:  return clex_pkg::K_BANG;
      clex_pkg::M_LT:    return clex_pkg::K_LT;
      clex_pkg::M_GT:    return clex_pkg::K_GT;
      clex_pkg::M_AMP:   return clex_pkg::K_AMP;
      clex_pkg::M_PIPE:  return clex_pkg::K_PIPE;
      default: return -1;
    endcase
  endfunction

  // feed c to the token in progress; 1 if c was used up
  function automatic bit extend_token(logic [7:0] c, logic [OFF_W-1:0] p);
    int k;
    case (lx_mode)
      clex_pkg::M_IDLE: return 1'b0;
      clex_pkg::M_IDENT: begin
        if (is_alpha(c) || is_num(c) || c == clex_pkg::CH_UNDER) begin
          grow();
          return 1'b1;
        end
        put_token(clex_pkg::K_IDENT, tok_start, tok_len, tok_line);
      end
      clex_pkg::M_INT, clex_pkg::M_FLOAT: begin
        if (is_num(c)) begin
          grow();
          return 1'b1;
        end
        if (c == clex_pkg::CH_DOT) begin
          if (lx_mode == clex_pkg::M_INT) begin
            lx_mode = clex_pkg::M_FLOAT;
            grow();
          end else begin
            fail_at(clex_pkg::K_DOT, p);
          end
          return 1'b1;
        end
        put_token(lx_mode == clex_pkg::M_INT ? clex_pkg::K_INT : clex_pkg::K_FLOAT,
                  tok_start, tok_len, tok_line);
      end
      clex_pkg::M_STRING: begin
        if (c == clex_pkg::CH_QUOTE) begin
          put_token(clex_pkg::K_STRING, tok_start, tok_len, tok_line);
          lx_mode = clex_pkg::M_IDLE;
          return 1'b1;
        end
        if (c == clex_pkg::CH_LF) next_line();
        grow();
        return 1'b1;
      end
      clex_pkg::M_COMMENT: begin
        if (c == clex_pkg::CH_LF) begin
          next_line();
          lx_mode = clex_pkg::M_IDLE;
        end
        return 1'b1;
      end
      default: begin
        if (lx_mode == clex_pkg::M_SLASH && c == clex_pkg::CH_SLASH) begin
          lx_mode = clex_pkg::M_COMMENT;
          return 1'b1;
        end
        k = pair_op(lx_mode, c);
        if (k >= 0) begin
          put_token(k, tok_start, LEN_W'(2), tok_line);
          lx_mode = clex_pkg::M_IDLE;
          return 1'b1;
        end
        k = lone_op(lx_mode);
        if (k >= 0) put_token(k, tok_start, LEN_W'(1), tok_line);
      end
    endcase
    lx_mode = clex_pkg::M_IDLE;
    return 1'b0;
  endfunction

  // c arrives with no token in progress
  function automatic void begin_token(logic [7:0] c, logic [OFF_W-1:0] p);
    int k;
    if (is_gap(c)) begin
      if (c == clex_pkg::CH_LF) next_line();
      return;
    end
    tok_start = p;
    tok_line  = cur_line;
    tok_len   = LEN_W'(1);
    if (is_alpha(c) || c == clex_pkg::CH_UNDER) begin
      lx_mode = clex_pkg::M_IDENT;
      return;
    end
    if (is_num(c)) begin
      lx_mode = clex_pkg::M_INT;
      return;
    end
    case (c)
      clex_pkg::CH_QUOTE: begin
        tok_start = p + OFF_W'(1);
        tok_len   = '0;
        lx_mode   = clex_pkg::M_STRING;
        return;
      end
      clex_pkg::CH_SLASH: begin lx_mode = clex_pkg::M_SLASH; return; end
      clex_pkg::CH_EQ:    begin lx_mode = clex_pkg::M_EQ;    return; end
      clex_pkg::CH_BANG:  begin lx_mode = clex_pkg::M_BANG;  return; end
      clex_pkg::CH_LT:    begin lx_mode = clex_pkg::M_LT;    return; end
      clex_pkg::CH_GT:    begin lx_mode = clex_pkg::M_GT;    return; end
      clex_pkg::CH_AMP:   begin lx_mode = clex_pkg::M_AMP;   return; end
      clex_pkg::CH_PIPE:  begin lx_mode = clex_pkg::M_PIPE;  return; end
      default: ;
    endcase
    k = single_op(c);
    if (k >= 0) put_token(k, p, LEN_W'(1), cur_line);
    else fail_at(clex_pkg::K_BAD, p);
  endfunction

  // end of text: flush the pending token, then the end token unless a string was left open
  function automatic void close_stream();
    case (lx_mode)
      clex_pkg::M_IDLE, clex_pkg::M_COMMENT: ;
      clex_pkg::M_IDENT: put_token(clex_pkg::K_IDENT, tok_start, tok_len, tok_line);
      clex_pkg::M_INT:   put_token(clex_pkg::K_INT, tok_start, tok_len, tok_line);
      clex_pkg::M_FLOAT: put_token(clex_pkg::K_FLOAT, tok_start, tok_len, tok_line);
      clex_pkg::M_STRING: begin
        put_token(clex_pkg::K_OPEN_STR, tok_start, tok_len, tok_line);
        return;
      end
      default: begin
        if (lone_op(lx_mode) >= 0)
          put_token(lone_op(lx_mode), tok_start, LEN_W'(1), tok_line);
      end
    endcase
    put_token(clex_pkg::K_END, cur_off, '0, cur_line);
  endfunction

  // tokens caused by one request, collected in step_toks
  function automatic void predict_item(logic [7:0] ch, logic pres, logic eot);
    logic [OFF_W-1:0] p;
    step_toks.delete();
    if (pres && !stopped) begin
      p = cur_off;
      if (!extend_token(ch, p) && !stopped) begin_token(ch, p);
      cur_off = p + OFF_W'(1);
    end
    if (eot) begin
      if (!stopped) close_stream();
      clear_lexer();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
  endfunction

  // request side: optional gap, then hold until taken
  task automatic send_item(input logic [7:0] ch, input logic pres, input logic eot);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= pres;
    s_tlast  <= eot;
    do @(posedge clk); while (s_tready !== 1'b1);
  endtask

  task automatic accept_item(input logic [7:0] ch, input logic pres, input logic eot);
    send_item(ch, pres, eot);
    predict_item(ch, pres, eot);
    foreach (step_toks[k]) token_q.push_back(step_toks[k]);
  endtask

  // stop sending until every expected token has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (token_q.size() != 0);
  endtask

  // random source fragment, mostly well formed
  function automatic void add_snippet();
    int pick, n, j;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      text.push_back(WORD_CHARS[$urandom_range(0, 52)]);
      n = $urandom_range(0, 6);
      repeat (n) text.push_back(WORD_CHARS[$urandom_range(0, 62)]);
    end else if (pick < 32) begin
      n = $urandom_range(1, 5);
      repeat (n) text.push_back(8'("0" + $urandom_range(0, 9)));
    end else if (pick < 40) begin
      n = $urandom_range(1, 3);
      repeat (n) text.push_back(8'("0" + $urandom_range(0, 9)));
      text.push_back(clex_pkg::CH_DOT);
      n = $urandom_range(0, 3);
      repeat (n) text.push_back(8'("0" + $urandom_range(0, 9)));
      // occasional second dot
      if ($urandom_range(0, 3) == 0) begin
        text.push_back(clex_pkg::CH_DOT);
        text.push_back(8'("0" + $urandom_range(0, 9)));
      end
    end else if (pick < 50) begin
      text.push_back(clex_pkg::CH_QUOTE);
      n = $urandom_range(0, 8);
      repeat (n) begin
        b = ($urandom_range(0, 5) == 0) ? clex_pkg::CH_LF : 8'($urandom_range(0, 255));
        text.push_back(b == clex_pkg::CH_QUOTE ? 8'h78 : b);
      end
      if ($urandom_range(0, 9) != 0) text.push_back(clex_pkg::CH_QUOTE);
    end else if (pick < 72) begin
      if ($urandom_range(0, 1) == 0) begin
        text.push_back(OP_ONE[$urandom_range(0, OP_ONE.len() - 1)]);
      end else begin
        j = 2 * $urandom_range(0, 7);
        text.push_back(OP_TWO[j]);
        text.push_back(OP_TWO[j + 1]);
      end
    end else if (pick < 88) begin
      text.push_back(BLANKS[$urandom_range(0, 5)]);
    end else if (pick < 95) begin
      text.push_back(clex_pkg::CH_SLASH);
      text.push_back(clex_pkg::CH_SLASH);
      n = $urandom_range(0, 6);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        text.push_back(b == clex_pkg::CH_LF ? 8'h63 : b);
      end
      if ($urandom_range(0, 3) != 0) text.push_back(clex_pkg::CH_LF);
    end else begin
      text.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // one source stream with stray empty requests, closed by end of text
  task automatic run_stream();
    int n_snip;
    bit tail_flag;
    text.delete();
    n_snip = $urandom_range(0, 12);
    repeat (n_snip) add_snippet();
    quiet_tx  = ($urandom_range(0, 4) == 0);
    tail_flag = ($urandom_range(0, 1) == 1) && (text.size() > 0);
    foreach (text[i]) begin
      if ($urandom_range(0, 19) == 0) accept_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      accept_item(text[i], 1'b1, tail_flag && (i == text.size() - 1));
    end
    if (!tail_flag) accept_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // result side: random stall per token, then compare with the oldest expectation
  initial begin
    int stall;
    token_t want;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = quiet_rx ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      if ($urandom_range(0, 29) == 0) quiet_rx = !quiet_rx;
      if (token_q.size() == 0) begin
        report_mismatch("unexpected, kind", m_tdata[KIND_W-1:0], -1);
      end else begin
        want = token_q.pop_front();
        if (m_tdata[KIND_W-1:0] !== want.kind)
          report_mismatch("kind", m_tdata[KIND_W-1:0], want.kind);
        if (m_tdata[START_LO +: OFF_W] !== want.start)
          report_mismatch("start", m_tdata[START_LO +: OFF_W], want.start);
        if (m_tdata[LEN_LO +: LEN_W] !== want.length)
          report_mismatch("length", m_tdata[LEN_LO +: LEN_W], want.length);
        if (m_tdata[LINE_LO +: LINE_W] !== want.line)
          report_mismatch("line", m_tdata[LINE_LO +: LINE_W], want.line);
        if (m_tlast !== want.last)
          report_mismatch("final flag", m_tlast, want.last);
      end
    end
  end

  // main sequence
  initial begin
    token_t want;
    int rand_bytes;
    bit paused;
    rand_bytes = 0;
    paused     = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (SCRIPT[r]) begin
      send_item(SCRIPT[r].ch, SCRIPT[r].pres, SCRIPT[r].eot);
      predict_item(SCRIPT[r].ch, SCRIPT[r].pres, SCRIPT[r].eot);
      if (SCRIPT[r].typed) begin
        want.kind   = SCRIPT[r].kind;
        want.start  = SCRIPT[r].start;
        want.length = SCRIPT[r].len;
        want.line   = SCRIPT[r].line;
        want.last   = 1'b1;
        token_q.push_back(want);
      end else begin
        foreach (step_toks[k]) token_q.push_back(step_toks[k]);
      end
    end
    drain();

    // random streams, with one full drain halfway
    while (rand_bytes < 280) begin
      if (!paused && rand_bytes >= 140) begin
        drain();
        paused = 1'b1;
      end
      run_stream();
      rand_bytes += text.size();
    end

    drain();
    repeat (16) @(posedge clk);
    if (err_count == 0)
      $display("c_style_token_lexer: match");
    else
      $display("c_style_token_lexer: mismatch");
    $finish;
  end

  // run time limit
  initial begin
    #20_000_000;
    $display("c_style_token_lexer: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/clex_pkg.sv
rtl/clex_step.sv
rtl/clex_rbuf.sv
rtl/c_style_token_lexer.sv
dv/tb_top.sv
